[design/mjs_pkg.sv]
// Shared types, constants and codes of the multi-core job scheduler.
// Used by the controller, the datapath and the top level; depends on nothing.
package mjs_pkg;

	localparam int MAX_CORES = 8;
	localparam int QDEPTH    = 32;
	localparam int CORE_W    = $clog2(MAX_CORES);
	localparam int QAW       = $clog2(QDEPTH);
	localparam int QCW       = QAW + 1;
	localparam int ACT_W     = 4;
	localparam int POL_W     = 3;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DAT_W = 4;

	// Event kinds; the last code is unused and changes nothing.
	localparam logic [1:0] MODE_ARRIVE = 2'd0;
	localparam logic [1:0] MODE_FINISH = 2'd1;
	localparam logic [1:0] MODE_EXPIRE = 2'd2;
	localparam logic [1:0] MODE_NONE   = 2'd3;

	// Scheduling policies.
	localparam logic [POL_W-1:0] POL_FCFS = 3'd0;
	localparam logic [POL_W-1:0] POL_SJF  = 3'd1;
	localparam logic [POL_W-1:0] POL_PSJF = 3'd2;
	localparam logic [POL_W-1:0] POL_PRI  = 3'd3;
	localparam logic [POL_W-1:0] POL_PPRI = 3'd4;
	localparam logic [POL_W-1:0] POL_RR   = 3'd5;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_POLICY = 1'd1;

	typedef struct packed {
		logic [1:0]  mode;
		logic [15:0] job_id;
		logic [31:0] now;
		logic [15:0] run_length;
		logic [15:0] job_priority;
		logic [2:0]  core_sel;
	} req_t;

	typedef struct packed {
		logic        scheduled;
		logic [2:0]  target_core;
		logic [15:0] job_out;
		logic        rejected;
	} res_t;

	// One waiting job.
	typedef struct packed {
		logic [15:0] job;
		logic [31:0] arrival;
		logic [15:0] remaining;
		logic [15:0] prio;
	} entry_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DECIDE,
		ST_PLACE,
		ST_SCAN_CALC,
		ST_SCAN_CMP,
		ST_VICTIM,
		ST_VREM,
		ST_PREEMPT,
		ST_EREM,
		ST_EXP_DECIDE,
		ST_DISP_RD,
		ST_DISP_WR,
		ST_INS_START,
		ST_INS_LOOP,
		ST_INS_TAIL,
		ST_DONE
	} state_t;

	// Controller to datapath.
	typedef struct packed {
		logic latch;
		logic sel_free;
		logic sel_victim;
		logic core_from_scan;
		logic rem_calc;
		logic scan_clr;
		logic scan_cmp;
		logic place_new;
		logic carry_core;
		logic carry_new;
		logic release_core;
		logic refresh_core;
		logic disp_rd;
		logic disp_wr;
		logic ins_start;
		logic ins_step;
		logic ins_tail;
		logic res_rej;
		logic res_new;
		logic res_core;
	} cmd_t;

	// Datapath to controller.
	typedef struct packed {
		logic [1:0]       mode;
		logic [POL_W-1:0] pol;
		logic             len_zero;
		logic             free_found;
		logic             q_full;
		logic             q_empty;
		logic             sel_ok;
		logic             scan_last;
		logic             victim_found;
		logic             tgt_busy;
		logic             rem_zero;
		logic             ins_last;
	} stat_t;

endpackage

[design/mjs_datapath.sv]
// Datapath of the job scheduler: configuration, core table, wait queue memory
// and result register. Depends on mjs_pkg; driven by mjs_controller.
module mjs_datapath (
	input  logic                      clk,
	input  logic                      arst_n,
	input  mjs_pkg::req_t             req,
	input  logic                      cfg_valid,
	input  logic [mjs_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [mjs_pkg::CFG_DAT_W-1:0] cfg_data,
	input  mjs_pkg::cmd_t             cmd,
	output mjs_pkg::stat_t            stat,
	output mjs_pkg::res_t             res
);
	import mjs_pkg::*;

	logic [ACT_W-1:0]  active_q;
	logic [POL_W-1:0]  policy_q;
	logic [POL_W-1:0]  pol;
	logic [ACT_W-1:0]  ncores;
	req_t              req_q;

	logic [MAX_CORES-1:0] busy_q;
	logic [15:0] core_job_q   [MAX_CORES];
	logic [31:0] core_arr_q   [MAX_CORES];
	logic [15:0] core_rem_q   [MAX_CORES];
	logic [15:0] core_prio_q  [MAX_CORES];
	logic [31:0] core_start_q [MAX_CORES];

	logic [CORE_W-1:0] tgt_q, scan_idx_q, victim_q, free_idx, core_idx;
	logic              free_found, vfound_q;
	logic [15:0]       worst_q, rem_q, rem_val, key, lim;
	logic [31:0]       elapsed;

	entry_t            mem [QDEPTH];
	entry_t            rd_q, carry_q, wr_data;
	logic              rd_en, wr_en, take;
	logic [QAW-1:0]    rd_addr, wr_addr, head_q;
	logic [QCW-1:0]    count_q, k_q;
	logic              found_q;
	res_t              res_q;

	// True when entry a strictly goes before entry b under policy p.
	function automatic logic precedes(entry_t a, entry_t b, logic [POL_W-1:0] p);
		logic r;
		r = 1'b0;
		case (p)
			POL_FCFS: r = a.arrival < b.arrival;
			POL_SJF, POL_PSJF: r = (a.remaining != b.remaining) ?
				(a.remaining < b.remaining) : (a.arrival < b.arrival);
			POL_PRI, POL_PPRI: r = (a.prio != b.prio) ?
				(a.prio < b.prio) : (a.arrival < b.arrival);
			default: r = 1'b0;
		endcase
		return r;
	endfunction

	// Configuration registers, with out-of-range values folded.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= ACT_W'(1);
			policy_q <= POL_FCFS;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_ACTIVE: active_q <= cfg_data[ACT_W-1:0];
				CFG_POLICY: policy_q <= cfg_data[POL_W-1:0];
				default: ;
			endcase
		end
	end

	assign pol    = (policy_q <= POL_RR) ? policy_q : POL_FCFS;
	assign ncores = (active_q == '0) ? ACT_W'(1) :
		(active_q > ACT_W'(MAX_CORES)) ? ACT_W'(MAX_CORES) : active_q;

	// Lowest idle core among those in use.
	always_comb begin
		free_found = 1'b0;
		free_idx   = '0;
		for (int i = MAX_CORES - 1; i >= 0; i--) begin
			if (!busy_q[i] && (ACT_W'(i) < ncores)) begin
				free_found = 1'b1;
				free_idx   = CORE_W'(i);
			end
		end
	end

	// Remaining run time of one core, saturating at zero.
	assign core_idx = cmd.core_from_scan ? scan_idx_q : tgt_q;
	assign elapsed  = (req_q.now >= core_start_q[core_idx]) ?
		(req_q.now - core_start_q[core_idx]) : '0;
	assign rem_val  = ({16'b0, core_rem_q[core_idx]} > elapsed) ?
		(core_rem_q[core_idx] - elapsed[15:0]) : '0;

	// Preemption key of the scanned core and the bound it must exceed.
	assign key = (pol == POL_PSJF) ? rem_q : core_prio_q[core_idx];
	assign lim = (pol == POL_PSJF) ? req_q.run_length : req_q.job_priority;

	// Item and working registers.
	always_ff @(posedge clk) begin
		if (cmd.latch) req_q <= req;
		if (cmd.rem_calc) rem_q <= rem_val;
		if (cmd.latch) tgt_q <= req.core_sel;
		else if (cmd.sel_free) tgt_q <= free_idx;
		else if (cmd.sel_victim) tgt_q <= victim_q;
		if (cmd.scan_cmp && key > lim && (!vfound_q || key > worst_q)) begin
			worst_q  <= key;
			victim_q <= scan_idx_q;
		end
		if (cmd.carry_new)
			carry_q <= '{req_q.job_id, req_q.now, req_q.run_length, req_q.job_priority};
		else if (cmd.carry_core)
			carry_q <= '{core_job_q[core_idx], core_arr_q[core_idx], rem_q,
				core_prio_q[core_idx]};
		else if (cmd.ins_step && take)
			carry_q <= rd_q;
	end

	// Victim scan control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_idx_q <= '0;
			vfound_q   <= 1'b0;
		end else if (cmd.scan_clr) begin
			scan_idx_q <= '0;
			vfound_q   <= 1'b0;
		end else if (cmd.scan_cmp) begin
			scan_idx_q <= scan_idx_q + CORE_W'(1);
			if (key > lim) vfound_q <= 1'b1;
		end
	end

	// Core table contents.
	always_ff @(posedge clk) begin
		if (cmd.place_new) begin
			core_job_q[tgt_q]   <= req_q.job_id;
			core_arr_q[tgt_q]   <= req_q.now;
			core_rem_q[tgt_q]   <= req_q.run_length;
			core_prio_q[tgt_q]  <= req_q.job_priority;
			core_start_q[tgt_q] <= req_q.now;
		end else if (cmd.disp_wr) begin
			core_job_q[tgt_q]   <= rd_q.job;
			core_arr_q[tgt_q]   <= rd_q.arrival;
			core_rem_q[tgt_q]   <= rd_q.remaining;
			core_prio_q[tgt_q]  <= rd_q.prio;
			core_start_q[tgt_q] <= req_q.now;
		end else if (cmd.refresh_core) begin
			core_rem_q[tgt_q]   <= rem_q;
			core_start_q[tgt_q] <= req_q.now;
		end
	end

	// Core busy bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) busy_q <= '0;
		else if (cmd.place_new || cmd.disp_wr) busy_q[tgt_q] <= 1'b1;
		else if (cmd.release_core) busy_q[tgt_q] <= 1'b0;
	end

	// Wait queue ports: a ring with its head at head_q.
	assign take    = found_q || precedes(carry_q, rd_q, pol);
	assign rd_en   = cmd.disp_rd || cmd.ins_start || cmd.ins_step;
	assign rd_addr = cmd.ins_step ? (head_q + k_q[QAW-1:0] + QAW'(1)) : head_q;
	assign wr_data = carry_q;
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = head_q;
		if (cmd.ins_start && count_q == '0) begin
			wr_en = 1'b1;
		end else if (cmd.ins_step && take) begin
			wr_en   = 1'b1;
			wr_addr = head_q + k_q[QAW-1:0];
		end else if (cmd.ins_tail) begin
			wr_en   = 1'b1;
			wr_addr = head_q + count_q[QAW-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= wr_data;
		if (rd_en) rd_q <= mem[rd_addr];
	end

	// Queue pointers and the insert walk.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			count_q <= '0;
			k_q     <= '0;
			found_q <= 1'b0;
		end else begin
			if (cmd.disp_wr) begin
				head_q  <= head_q + QAW'(1);
				count_q <= count_q - QCW'(1);
			end else if ((cmd.ins_start && count_q == '0) || cmd.ins_tail) begin
				count_q <= count_q + QCW'(1);
			end
			if (cmd.ins_start) begin
				k_q     <= '0;
				found_q <= 1'b0;
			end else if (cmd.ins_step) begin
				k_q <= k_q + QCW'(1);
				if (take) found_q <= 1'b1;
			end
		end
	end

	// Result register.
	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			res_q <= '0;
		end else if (cmd.res_rej) begin
			res_q.rejected <= 1'b1;
		end else if (cmd.res_new) begin
			res_q <= '{1'b1, tgt_q, req_q.job_id, 1'b0};
		end else if (cmd.disp_wr) begin
			res_q <= '{1'b1, tgt_q, rd_q.job, 1'b0};
		end else if (cmd.res_core) begin
			res_q <= '{1'b1, tgt_q, core_job_q[core_idx], 1'b0};
		end
	end
	assign res = res_q;

	// Status towards the controller.
	assign stat.mode         = req_q.mode;
	assign stat.pol          = pol;
	assign stat.len_zero     = req_q.run_length == '0;
	assign stat.free_found   = free_found;
	assign stat.q_full       = count_q == QCW'(QDEPTH);
	assign stat.q_empty      = count_q == '0;
	assign stat.sel_ok       = {1'b0, req_q.core_sel} < ncores;
	assign stat.scan_last    = {1'b0, scan_idx_q} == (ncores - ACT_W'(1));
	assign stat.victim_found = vfound_q;
	assign stat.tgt_busy     = busy_q[core_idx];
	assign stat.rem_zero     = rem_q == '0;
	assign stat.ins_last     = (k_q + QCW'(1)) >= count_q;

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= QCW'(QDEPTH)) else $error("wait queue count beyond depth");
	a_disp_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.disp_wr |-> count_q != '0) else $error("dispatch from empty queue");
	a_ins_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.ins_start |-> count_q < QCW'(QDEPTH)) else $error("insert into full queue");
	a_place_core: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.place_new |=> busy_q[$past(tgt_q)]) else $error("placed core not busy");

endmodule

[design/mjs_controller.sv]
// Sequencing state machine of the job scheduler.
// Depends on mjs_pkg; issues commands to mjs_datapath and reads its status.
module mjs_controller (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  mjs_pkg::stat_t stat,
	output mjs_pkg::cmd_t  cmd,
	output logic           busy,
	output logic           done
);
	import mjs_pkg::*;

	state_t state_q, state_d;
	logic   pend_ins_q, pend_ins_d;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			pend_ins_q <= 1'b0;
		end else begin
			state_q    <= state_d;
			pend_ins_q <= pend_ins_d;
		end
	end

	// Next state and commands.
	always_comb begin
		state_d    = state_q;
		pend_ins_d = pend_ins_q;
		cmd        = '0;
		done       = 1'b0;
		busy       = state_q != ST_IDLE;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.latch  = 1'b1;
					pend_ins_d = 1'b0;
					state_d    = ST_DECIDE;
				end
			end
			ST_DECIDE: begin
				unique case (stat.mode)
					MODE_ARRIVE: begin
						if (stat.len_zero) begin
							cmd.res_rej = 1'b1;
							state_d     = ST_DONE;
						end else if (stat.free_found) begin
							cmd.sel_free = 1'b1;
							state_d      = ST_PLACE;
						end else if (stat.q_full) begin
							cmd.res_rej = 1'b1;
							state_d     = ST_DONE;
						end else if (stat.pol == POL_PSJF || stat.pol == POL_PPRI) begin
							cmd.scan_clr = 1'b1;
							state_d      = ST_SCAN_CALC;
						end else begin
							cmd.carry_new = 1'b1;
							state_d       = ST_INS_START;
						end
					end
					MODE_FINISH: begin
						if (stat.sel_ok) begin
							cmd.release_core = 1'b1;
							state_d = stat.q_empty ? ST_DONE : ST_DISP_RD;
						end else begin
							state_d = ST_DONE;
						end
					end
					MODE_EXPIRE: begin
						if (stat.pol == POL_RR && stat.sel_ok) begin
							if (stat.tgt_busy) state_d = ST_EREM;
							else state_d = stat.q_empty ? ST_DONE : ST_DISP_RD;
						end else begin
							state_d = ST_DONE;
						end
					end
					default: state_d = ST_DONE;
				endcase
			end
			ST_PLACE: begin
				cmd.place_new = 1'b1;
				cmd.res_new   = 1'b1;
				state_d       = ST_DONE;
			end
			ST_SCAN_CALC: begin
				cmd.core_from_scan = 1'b1;
				cmd.rem_calc       = 1'b1;
				state_d            = ST_SCAN_CMP;
			end
			ST_SCAN_CMP: begin
				cmd.core_from_scan = 1'b1;
				cmd.scan_cmp       = 1'b1;
				state_d = stat.scan_last ? ST_VICTIM : ST_SCAN_CALC;
			end
			ST_VICTIM: begin
				if (stat.victim_found) begin
					cmd.sel_victim = 1'b1;
					state_d        = ST_VREM;
				end else begin
					cmd.carry_new = 1'b1;
					state_d       = ST_INS_START;
				end
			end
			ST_VREM: begin
				cmd.rem_calc = 1'b1;
				state_d      = ST_PREEMPT;
			end
			ST_PREEMPT: begin
				// Requeue the preempted job and put the new one in its place.
				cmd.carry_core = 1'b1;
				cmd.place_new  = 1'b1;
				cmd.res_new    = 1'b1;
				state_d        = ST_INS_START;
			end
			ST_EREM: begin
				cmd.rem_calc = 1'b1;
				state_d      = ST_EXP_DECIDE;
			end
			ST_EXP_DECIDE: begin
				if (stat.rem_zero) begin
					cmd.release_core = 1'b1;
					state_d = stat.q_empty ? ST_DONE : ST_DISP_RD;
				end else if (!stat.q_empty) begin
					cmd.carry_core = 1'b1;
					pend_ins_d     = 1'b1;
					state_d        = ST_DISP_RD;
				end else begin
					cmd.refresh_core = 1'b1;
					cmd.res_core     = 1'b1;
					state_d          = ST_DONE;
				end
			end
			ST_DISP_RD: begin
				cmd.disp_rd = 1'b1;
				state_d     = ST_DISP_WR;
			end
			ST_DISP_WR: begin
				cmd.disp_wr = 1'b1;
				state_d = pend_ins_q ? ST_INS_START : ST_DONE;
			end
			ST_INS_START: begin
				cmd.ins_start = 1'b1;
				state_d = stat.q_empty ? ST_DONE : ST_INS_LOOP;
			end
			ST_INS_LOOP: begin
				cmd.ins_step = 1'b1;
				if (stat.ins_last) state_d = ST_INS_TAIL;
			end
			ST_INS_TAIL: begin
				cmd.ins_tail = 1'b1;
				state_d      = ST_DONE;
			end
			ST_DONE: begin
				done    = 1'b1;
				state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

[design/multicore_job_scheduler_unit.sv]
// Top level of the multi-core job scheduler.
// Depends on mjs_pkg, mjs_controller and mjs_datapath.
//
// One event is taken at a time: start is accepted while busy is low, and the
// single result appears on res for exactly one cycle with res_valid high; the
// receiver cannot stall it. An event is rejected or ignored, places an
// arriving job on an idle core, refreshes a quantum, or dispatches a waiting
// job after a finish or an expiry. A preemption check scans the cores in use
// and, when it finds a victim, places the new job there; the job left over
// goes into the wait queue. Inserting into the wait queue walks the queue
// memory one entry a cycle, or writes directly when the queue is empty. That
// walk sets the worst case: a preemption over eight cores that requeues the
// old job behind 31 waiting ones.
// Configuration writes are always accepted and belong in idle periods.
module multicore_job_scheduler_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  mjs_pkg::req_t                 req,
	output logic                          res_valid,
	output mjs_pkg::res_t                 res,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [mjs_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [mjs_pkg::CFG_DAT_W-1:0] cfg_data
);
	import mjs_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	assign cfg_ready = 1'b1;

	mjs_controller u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy),
		.done   (res_valid)
	);

	mjs_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cfg_valid (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.stat      (stat),
		.res       (res)
	);

endmodule
